/* hw/rtl/eis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eis_pkg: shared types for the external interrupt sense and select block
// Sense mode codes, configuration register indexes and the result record
// passed from the sense logic to the result register.
// ----------------------------------------------------------------------------
package eis_pkg;

    // INT0 sense mode
    typedef enum logic [1:0] {
        SENSE_LOW  = 2'd0,
        SENSE_ANY  = 2'd1,
        SENSE_FALL = 2'd2,
        SENSE_RISE = 2'd3
    } sense_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INT0_ENABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_CHANGE_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INT0_SENSE        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_CHANGE_MASK   = 2'd3;

    // Vector codes
    localparam logic VEC_INT0       = 1'b0;
    localparam logic VEC_PIN_CHANGE = 1'b1;

    // One result item plus the flag values that become the new state
    typedef struct packed {
        logic take;
        logic vec;
        logic int0_flag;
        logic change_flag;
    } eis_result_t;

endpackage
`default_nettype wire

/* hw/rtl/eis_sense.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eis_sense: INT0 edge/level sense, pin change detect and vector select
// Pure combinational step: from one registered pin sample and the current
// state, compute the updated flags and the interrupt decision.
// ----------------------------------------------------------------------------
module eis_sense
    import eis_pkg::*;
#(
    parameter int unsigned PIN_COUNT      = 6,
    parameter int unsigned INT0_PIN_INDEX = 1
)
(
    input  wire logic [PIN_COUNT-1:0] pins,
    input  wire logic                 boundary,
    input  wire logic                 gie,
    input  wire logic [PIN_COUNT-1:0] last_pins,
    input  wire logic                 primed,
    input  wire logic                 int0_flag,
    input  wire logic                 change_flag,
    input  wire logic                 int0_enable,
    input  wire logic                 pin_change_enable,
    input  wire sense_t               int0_sense,
    input  wire logic [PIN_COUNT-1:0] pin_change_mask,
    output eis_result_t               result
);

    logic [PIN_COUNT-1:0] prev_pins;
    logic                 now0;
    logic                 was0;
    logic                 int0_upd;
    logic                 change_upd;
    logic                 low_req;

    // Use the current sample as the previous one on the very first sample
    assign prev_pins = primed ? last_pins : pins;
    assign now0      = pins[INT0_PIN_INDEX];
    assign was0      = prev_pins[INT0_PIN_INDEX];
    assign low_req   = (int0_sense == SENSE_LOW) && !now0;

    // Update INT0 flag per sense mode
    always_comb
    begin
        int0_upd = int0_flag;
        if (int0_enable)
        begin
            case (int0_sense)
                SENSE_LOW:  int0_upd = 1'b0;
                SENSE_ANY:  if (now0 != was0) int0_upd = 1'b1;
                SENSE_FALL: if (!now0 && was0) int0_upd = 1'b1;
                SENSE_RISE: if (now0 && !was0) int0_upd = 1'b1;
                default:    int0_upd = int0_flag;
            endcase
        end
    end

    // Set pin change flag on any masked change while pin change is enabled
    assign change_upd = change_flag ||
                        (pin_change_enable && (|((pins ^ prev_pins) & pin_change_mask)));

    // Select vector at a boundary with GIE, INT0 first; clear the chosen flag
    always_comb
    begin
        result.take        = 1'b0;
        result.vec         = VEC_INT0;
        result.int0_flag   = int0_upd;
        result.change_flag = change_upd;
        if (boundary && gie)
        begin
            if (int0_enable && (low_req || int0_upd))
            begin
                result.take      = 1'b1;
                result.vec       = VEC_INT0;
                result.int0_flag = 1'b0;
            end
            else if (pin_change_enable && change_upd)
            begin
                result.take        = 1'b1;
                result.vec         = VEC_PIN_CHANGE;
                result.change_flag = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/external_interrupt_sense_and_select_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// external_interrupt_sense_and_select_top: INT0 and pin change interrupts
// Samples port pins once per transfer, tracks the INT0 and pin change flags
// and reports which interrupt, if any, is taken at an instruction boundary.
//
// Input channel (in_valid/in_ready) carries one pin sample with the boundary
// mark and global enable; output channel (out_valid/out_ready) returns one
// result per input: take, vector and both flag values after that sample.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// must only change while no sample is in flight.
// The path is an input register, then sense/select logic into a result
// register. Throughput is one sample per cycle while out_ready is high; the
// flags and last pin sample are updated in the cycle an item moves into the
// result register. When the receiver stalls, the result register holds and
// the input register fills; in_ready drops only when both are occupied.
// Reset clears configuration, flags, the last sample and the primed bit, so
// the first sample after reset records the pins and sees no edge.
// ----------------------------------------------------------------------------
module external_interrupt_sense_and_select_top
    import eis_pkg::*;
#(
    parameter int unsigned PIN_COUNT      = 6,
    parameter int unsigned INT0_PIN_INDEX = 1
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [((PIN_COUNT > 2) ? PIN_COUNT : 2)-1:0] cfg_wdata,
    // Input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [PIN_COUNT-1:0]            pin_levels,
    input  wire logic                            at_boundary,
    input  wire logic                            global_enable,
    // Output channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 take_interrupt,
    output logic                                 vector_select,
    output logic                                 int0_pending,
    output logic                                 pin_change_pending
);

    // Configuration registers
    logic                 int0_enable_reg;
    logic                 pin_change_enable_reg;
    sense_t               int0_sense_reg;
    logic [PIN_COUNT-1:0] pin_change_mask_reg;

    // Input stage
    logic                 in_valid_reg;
    logic [PIN_COUNT-1:0] pins_reg;
    logic                 boundary_reg;
    logic                 gie_reg;

    // Block state
    logic [PIN_COUNT-1:0] last_pins_reg;
    logic                 primed_reg;
    logic                 int0_flag_reg;
    logic                 change_flag_reg;

    // Result stage
    logic                 out_valid_reg;
    eis_result_t          result_reg;
    eis_result_t          result_next;

    logic                 advance;

    // Move the input item on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int0_enable_reg       <= 1'b0;
            pin_change_enable_reg <= 1'b0;
            int0_sense_reg        <= SENSE_LOW;
            pin_change_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INT0_ENABLE:       int0_enable_reg       <= cfg_wdata[0];
                CFG_PIN_CHANGE_ENABLE: pin_change_enable_reg <= cfg_wdata[0];
                CFG_INT0_SENSE:        int0_sense_reg        <= sense_t'(cfg_wdata[1:0]);
                CFG_PIN_CHANGE_MASK:   pin_change_mask_reg   <= cfg_wdata[PIN_COUNT-1:0];
                default:               ;
            endcase
        end
    end

    // Hold input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Capture input payload on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pins_reg     <= pin_levels;
            boundary_reg <= at_boundary;
            gie_reg      <= global_enable;
        end
    end

    eis_sense #(
        .PIN_COUNT      (PIN_COUNT),
        .INT0_PIN_INDEX (INT0_PIN_INDEX)
    ) u_sense (
        .pins              (pins_reg),
        .boundary          (boundary_reg),
        .gie               (gie_reg),
        .last_pins         (last_pins_reg),
        .primed            (primed_reg),
        .int0_flag         (int0_flag_reg),
        .change_flag       (change_flag_reg),
        .int0_enable       (int0_enable_reg),
        .pin_change_enable (pin_change_enable_reg),
        .int0_sense        (int0_sense_reg),
        .pin_change_mask   (pin_change_mask_reg),
        .result            (result_next)
    );

    // Advance state with each item that enters the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pins_reg   <= '0;
            primed_reg      <= 1'b0;
            int0_flag_reg   <= 1'b0;
            change_flag_reg <= 1'b0;
        end
        else if (advance)
        begin
            last_pins_reg   <= pins_reg;
            primed_reg      <= 1'b1;
            int0_flag_reg   <= result_next.int0_flag;
            change_flag_reg <= result_next.change_flag;
        end
    end

    // Hold result valid until the output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign take_interrupt     = result_reg.take;
    assign vector_select      = result_reg.vec;
    assign int0_pending       = result_reg.int0_flag;
    assign pin_change_pending = result_reg.change_flag;

`ifndef SYNTHESIS
    // Taking INT0 leaves its flag clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.take && (result_reg.vec == VEC_INT0)
            |-> !result_reg.int0_flag)
        else $error("INT0 taken but flag still pending");

    // Taking pin change leaves its flag clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.take && (result_reg.vec == VEC_PIN_CHANGE)
            |-> !result_reg.change_flag)
        else $error("pin change taken but flag still pending");

    // No vector reported without a take
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.take |-> (result_reg.vec == VEC_INT0))
        else $error("vector select set with no interrupt taken");

    // An item moved on shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && (result_reg.int0_flag == int0_flag_reg)
            && (result_reg.change_flag == change_flag_reg))
        else $error("result register and flag state disagree");
`endif

endmodule
`default_nettype wire

/* test/tb_external_interrupt_sense_and_select_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_external_interrupt_sense_and_select_top: INT0 and pin change interrupt test
// Drives pin samples with boundary and global enable marks through the input
// channel and checks each result against a cycle-free predictor of the INT0
// sense logic, the pin change detector and the vector priority. Directed cases
// cover the first sample, every sense mode and disabled sources. Random traffic
// follows under several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_external_interrupt_sense_and_select_top;
    import eis_pkg::*;

    localparam int PIN_W       = 6;
    localparam int INT0_PIN    = 1;
    localparam int STALL_LIMIT = 1000;
    localparam int BATCH_ITEMS = 100;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_INT0_ENABLE;
    logic [PIN_W-1:0]      cfg_wdata     = '0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [PIN_W-1:0]      pin_levels    = '0;
    logic                  at_boundary   = 1'b0;
    logic                  global_enable = 1'b0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic                  take_interrupt;
    logic                  vector_select;
    logic                  int0_pending;
    logic                  pin_change_pending;

    // Predictor state and its copy of the registers
    logic [PIN_W-1:0]      seen_pins      = '0;
    logic                  pins_recorded  = 1'b0;
    logic                  int0_latched   = 1'b0;
    logic                  change_latched = 1'b0;
    logic                  cfg_int0_en    = 1'b0;
    logic                  cfg_pc_en      = 1'b0;
    sense_t                cfg_sense      = SENSE_LOW;
    logic [PIN_W-1:0]      cfg_mask       = '0;

    eis_result_t           predicted_results[$];
    logic [PIN_W-1:0]      last_sent_pins = '0;
    int                    send_idle_pct  = 9;
    int                    recv_idle_pct  = 52;
    int                    error_count    = 0;
    int                    stall_cycles   = 0;
    int                    batch_count    = 0;

    external_interrupt_sense_and_select_top u_top
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .pin_levels         (pin_levels),
        .at_boundary        (at_boundary),
        .global_enable      (global_enable),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .take_interrupt     (take_interrupt),
        .vector_select      (vector_select),
        .int0_pending       (int0_pending),
        .pin_change_pending (pin_change_pending)
    );

    always #1 clk = ~clk;

    // Compute the result of one pin sample and advance the flag state
    function automatic eis_result_t predict_interrupt(input logic [PIN_W-1:0] pins,
                                                      input logic bnd, input logic gie);
        eis_result_t res;
        logic        now0;
        logic        was0;
        res = '0;
        if (!pins_recorded)
        begin
            seen_pins     = pins;
            pins_recorded = 1'b1;
        end
        now0 = pins[INT0_PIN];
        was0 = seen_pins[INT0_PIN];
        if (cfg_int0_en)
        begin
            case (cfg_sense)
                SENSE_LOW:  int0_latched = 1'b0;
                SENSE_ANY:  if (now0 != was0) int0_latched = 1'b1;
                SENSE_FALL: if (!now0 && was0) int0_latched = 1'b1;
                default:    if (now0 && !was0) int0_latched = 1'b1;
            endcase
        end
        if (cfg_pc_en && (((pins ^ seen_pins) & cfg_mask) != '0))
            change_latched = 1'b1;
        seen_pins = pins;
        // INT0 wins over pin change
        if (bnd && gie)
        begin
            if (cfg_int0_en && (((cfg_sense == SENSE_LOW) && !now0) || int0_latched))
            begin
                res.take     = 1'b1;
                res.vec      = VEC_INT0;
                int0_latched = 1'b0;
            end
            else if (cfg_pc_en && change_latched)
            begin
                res.take       = 1'b1;
                res.vec        = VEC_PIN_CHANGE;
                change_latched = 1'b0;
            end
        end
        res.int0_flag   = int0_latched;
        res.change_flag = change_latched;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Offer one sample, hold it until the transfer, then predict its result
    task automatic send_sample(input logic [PIN_W-1:0] pins, input logic bnd,
                               input logic gie);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        pin_levels    <= pins;
        at_boundary   <= bnd;
        global_enable <= gie;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted_results.push_back(predict_interrupt(pins, bnd, gie));
        last_sent_pins = pins;
    endtask

    // Drop valid and wait until every predicted result has been checked
    task automatic drain_results();
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
    endtask

    // Write all four registers while the block is empty
    task automatic set_config(input logic int0_en, input logic pc_en,
                              input sense_t sense, input logic [PIN_W-1:0] mask);
        logic [PIN_W-1:0] value [4];
        drain_results();
        value[CFG_INT0_ENABLE]       = {{(PIN_W-1){1'b0}}, int0_en};
        value[CFG_PIN_CHANGE_ENABLE] = {{(PIN_W-1){1'b0}}, pc_en};
        value[CFG_INT0_SENSE]        = {{(PIN_W-2){1'b0}}, sense};
        value[CFG_PIN_CHANGE_MASK]   = mask;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= value[i];
            @(posedge clk);
        end
        cfg_we      <= 1'b0;
        cfg_int0_en = int0_en;
        cfg_pc_en   = pc_en;
        cfg_sense   = sense;
        cfg_mask    = mask;
    endtask

    // First sample records pins only; then INT0 beats a pending pin change
    task automatic test_first_sample();
        set_config(1'b1, 1'b1, SENSE_ANY, 6'h3F);
        send_sample(6'h3F, 1'b1, 1'b1);
        send_sample(6'h3D, 1'b1, 1'b1);
        send_sample(6'h3D, 1'b1, 1'b1);
    endtask

    // Low level: the pin itself requests, only at a boundary with GIE set
    task automatic test_low_level();
        set_config(1'b1, 1'b0, SENSE_LOW, 6'h00);
        send_sample(6'h3F, 1'b1, 1'b1);
        send_sample(6'h00, 1'b0, 1'b1);
        send_sample(6'h00, 1'b1, 1'b0);
        send_sample(6'h00, 1'b1, 1'b1);
    endtask

    // Falling and rising edges latch the flag until a boundary takes it
    task automatic test_edge_modes();
        set_config(1'b1, 1'b0, SENSE_FALL, 6'h00);
        send_sample(6'h02, 1'b0, 1'b1);
        send_sample(6'h00, 1'b0, 1'b1);
        send_sample(6'h02, 1'b1, 1'b1);
        set_config(1'b1, 1'b0, SENSE_RISE, 6'h00);
        send_sample(6'h00, 1'b0, 1'b1);
        send_sample(6'h02, 1'b1, 1'b1);
    endtask

    // Disabled sources keep their flags; low level needs INT0 enabled
    task automatic test_disabled_sources();
        set_config(1'b1, 1'b1, SENSE_FALL, 6'h3F);
        send_sample(6'h02, 1'b0, 1'b1);
        send_sample(6'h00, 1'b0, 1'b1);
        set_config(1'b0, 1'b0, SENSE_ANY, 6'h00);
        send_sample(6'h3F, 1'b1, 1'b1);
        send_sample(6'h00, 1'b1, 1'b1);
        set_config(1'b0, 1'b1, SENSE_LOW, 6'h00);
        send_sample(6'h00, 1'b1, 1'b1);
        send_sample(6'h00, 1'b1, 1'b1);
    endtask

    // Random batches, each under its own register setting
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int batches);
        logic [PIN_W-1:0] pins;
        logic [PIN_W-1:0] mask;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int b = 0; b < batches; b++)
        begin
            // Start with the extreme settings, then pick at random
            case (batch_count)
                0:       set_config(1'b1, 1'b1, SENSE_LOW, 6'h3F);
                1:       set_config(1'b1, 1'b1, SENSE_ANY, 6'h00);
                2:       set_config(1'b1, 1'b1, SENSE_FALL, 6'h2A);
                3:       set_config(1'b0, 1'b1, SENSE_RISE, 6'h15);
                default:
                begin
                    case ($urandom_range(7))
                        0:       mask = 6'h00;
                        1:       mask = 6'h3F;
                        default: mask = PIN_W'($urandom_range(63));
                    endcase
                    set_config($urandom_range(3) != 0, $urandom_range(3) != 0,
                               sense_t'($urandom_range(3)), mask);
                end
            endcase
            batch_count++;
            for (int n = 0; n < BATCH_ITEMS; n++)
            begin
                // Half single-pin toggles so edges and changes stay frequent
                case ($urandom_range(3))
                    0:       pins = PIN_W'($urandom_range(63));
                    1:       pins = last_sent_pins;
                    default: pins = last_sent_pins ^ (PIN_W'(1) << $urandom_range(PIN_W - 1));
                endcase
                send_sample(pins, 1'($urandom_range(1)), $urandom_range(9) < 7);
                if (b == 1 && n == BATCH_ITEMS / 2)
                    drain_results();
            end
        end
    endtask

    // Check every result transfer against the oldest prediction
    always @(posedge clk)
    begin
        eis_result_t want;
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("result transfer with no prediction waiting");
            else
            begin
                want = predicted_results.pop_front();
                if (take_interrupt !== want.take)
                    report_mismatch($sformatf("take_interrupt got %b want %b",
                                              take_interrupt, want.take));
                if (vector_select !== want.vec)
                    report_mismatch($sformatf("vector_select got %b want %b",
                                              vector_select, want.vec));
                if (int0_pending !== want.int0_flag)
                    report_mismatch($sformatf("int0_pending got %b want %b",
                                              int0_pending, want.int0_flag));
                if (pin_change_pending !== want.change_flag)
                    report_mismatch($sformatf("pin_change_pending got %b want %b",
                                              pin_change_pending, want.change_flag));
            end
        end
    end

    // Stop the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_sample();
        test_low_level();
        test_edge_modes();
        test_disabled_sources();
        test_random_traffic(9, 52, 5);
        test_random_traffic(52, 9, 5);
        test_random_traffic(0, 0, 4);
        drain_results();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* external_interrupt_sense_and_select_top.f */
hw/rtl/eis_pkg.sv
hw/rtl/eis_sense.sv
hw/rtl/external_interrupt_sense_and_select_top.sv
test/tb_external_interrupt_sense_and_select_top.sv
